// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is held
`define PFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds across reset
`define PFS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pfs_pkg.sv
// shared types and constants of the phong fragment shader
package pfs_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd5;

    // signed q2.30 unit component
    typedef logic signed [31:0] t_unit;
    typedef t_unit [2:0] t_unit_vec;

    // raw vector component, exact difference of two q16.16 values
    typedef logic signed [32:0] t_raw;
    typedef t_raw [2:0] t_raw_vec;

    // pipeline advance and the valid bit entering a unit
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// File: rtl/pfs_sqrt_pipe.sv
// pipelined 64-bit integer square root, one root bit per stage
module pfs_sqrt_pipe #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfs_pkg::t_pipe_ctl   i_ctl,
    input  logic [63:0]          i_radicand,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [31:0]          o_root,
    output logic [SIDE_W-1:0]    o_side
);
    localparam int unsigned NSTG = 32;

    logic [63:0]       r_rem  [NSTG];
    logic [31:0]       r_root [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];
    logic [NSTG-1:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[NSTG-2:0], i_ctl.valid};
        end
    end

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int unsigned B = NSTG - 1 - k;
        logic [63:0]       rem_in;
        logic [63:0]       term;
        logic [63:0]       n_rem;
        logic [31:0]       root_in;
        logic [31:0]       n_root;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // remainder holds x - root^2, try setting root bit b
        always_comb begin
            term = (64'(root_in) << (B + 1)) + (64'd1 << (2 * B));
            if (rem_in >= term) begin
                n_rem  = rem_in - term;
                n_root = root_in | (32'd1 << B);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_root  = r_root[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

// File: rtl/pfs_unitize.sv
// pipelined vector normalizer: scale, length by square root, divide per component
module pfs_unitize (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfs_pkg::t_pipe_ctl i_ctl,
    input  pfs_pkg::t_raw_vec  i_vec,
    output logic               o_valid,
    output pfs_pkg::t_unit_vec o_unit
);
    import pfs_pkg::*;

    localparam int unsigned MAG_W   = 31;
    localparam int unsigned SIDE_W  = 3 * MAG_W + 3 + 1;
    localparam int unsigned DIV_STG = 31;

    // stage a: magnitudes
    logic [32:0] n_a_mag [3];
    logic [2:0]  n_a_neg;
    logic [32:0] r_a_mag [3];
    logic [2:0]  r_a_neg;
    logic        r_a_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_neg[i] = i_vec[i][32];
            n_a_mag[i] = n_a_neg[i] ? 33'(-i_vec[i]) : 33'(i_vec[i]);
        end
    end

    // stage b: leading one of the largest magnitude
    logic [32:0] n_b_or;
    logic [5:0]  n_b_msb;
    logic [32:0] r_b_mag [3];
    logic [2:0]  r_b_neg;
    logic [5:0]  r_b_msb;
    logic        r_b_zero;
    logic        r_b_vld;

    always_comb begin
        n_b_or  = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        n_b_msb = '0;
        for (int b = 0; b < 33; b++) begin
            if (n_b_or[b]) begin
                n_b_msb = 6'(b);
            end
        end
    end

    // stage c: bring leading one to bit 30
    logic [MAG_W-1:0] n_c_mag [3];
    logic [MAG_W-1:0] r_c_mag [3];
    logic [2:0]       r_c_neg;
    logic             r_c_zero;
    logic             r_c_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_b_msb > 6'd30) begin
                n_c_mag[i] = MAG_W'(r_b_mag[i] >> (r_b_msb - 6'd30));
            end else begin
                n_c_mag[i] = MAG_W'(r_b_mag[i] << (6'd30 - r_b_msb));
            end
        end
    end

    // stage d: squares, stage e: sum of squares
    logic [61:0]      r_d_sq  [3];
    logic [MAG_W-1:0] r_d_mag [3];
    logic [2:0]       r_d_neg;
    logic             r_d_zero;
    logic             r_d_vld;
    logic [63:0]      n_e_sum;
    logic [63:0]      r_e_sum;
    logic [MAG_W-1:0] r_e_mag [3];
    logic [2:0]       r_e_neg;
    logic             r_e_zero;
    logic             r_e_vld;

    assign n_e_sum = 64'(r_d_sq[0]) + 64'(r_d_sq[1]) + 64'(r_d_sq[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_vld <= i_ctl.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= n_a_neg;
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_msb  <= n_b_msb;
            r_b_zero <= (n_b_or == '0);
            r_c_mag  <= n_c_mag;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= r_c_mag[i] * r_c_mag[i];
            end
            r_d_mag  <= r_c_mag;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
            r_e_sum  <= n_e_sum;
            r_e_mag  <= r_d_mag;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;
        end
    end

    // length
    t_pipe_ctl         w_sq_ctl;
    logic [SIDE_W-1:0] w_sq_side_in;
    logic [SIDE_W-1:0] w_sq_side;
    logic [31:0]       w_root;
    logic              w_sq_vld;
    logic [MAG_W-1:0]  w_sq_mag [3];
    logic [2:0]        w_sq_neg;
    logic              w_sq_zero;

    assign w_sq_ctl     = '{en: i_ctl.en, valid: r_e_vld};
    assign w_sq_side_in = {r_e_mag[2], r_e_mag[1], r_e_mag[0], r_e_neg, r_e_zero};

    pfs_sqrt_pipe #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sq_ctl),
        .i_radicand (r_e_sum),
        .i_side     (w_sq_side_in),
        .o_valid    (w_sq_vld),
        .o_root     (w_root),
        .o_side     (w_sq_side)
    );

    assign {w_sq_mag[2], w_sq_mag[1], w_sq_mag[0], w_sq_neg, w_sq_zero} = w_sq_side;

    // restoring division mag * 2^30 / len, one quotient bit per stage
    logic [32:0]        r_dv_rem  [DIV_STG][3];
    logic [MAG_W-1:0]   r_dv_q    [DIV_STG][3];
    logic [31:0]        r_dv_len  [DIV_STG];
    logic [2:0]         r_dv_neg  [DIV_STG];
    logic               r_dv_zero [DIV_STG];
    logic [DIV_STG-1:0] r_dv_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else if (i_ctl.en) begin
            r_dv_vld <= {r_dv_vld[DIV_STG-2:0], w_sq_vld};
        end
    end

    for (genvar j = 0; j < DIV_STG; j++) begin : g_div
        localparam int unsigned B = DIV_STG - 1 - j;
        logic [32:0]      rem_in [3];
        logic [MAG_W-1:0] q_in   [3];
        logic [31:0]      len_in;
        logic [2:0]       neg_in;
        logic             zero_in;
        logic [32:0]      diff   [3];
        logic [32:0]      n_rem  [3];
        logic [MAG_W-1:0] n_q    [3];

        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = {2'b00, w_sq_mag[i]};
                    q_in[i]   = '0;
                end
            end
            assign len_in  = w_root;
            assign neg_in  = w_sq_neg;
            assign zero_in = w_sq_zero;
        end else begin : g_next
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = r_dv_rem[j-1][i];
                    q_in[i]   = r_dv_q[j-1][i];
                end
            end
            assign len_in  = r_dv_len[j-1];
            assign neg_in  = r_dv_neg[j-1];
            assign zero_in = r_dv_zero[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                diff[i] = rem_in[i] - {1'b0, len_in};
                if (rem_in[i] >= {1'b0, len_in}) begin
                    n_rem[i] = {diff[i][31:0], 1'b0};
                    n_q[i]   = q_in[i] | (MAG_W'(1) << B);
                end else begin
                    n_rem[i] = {rem_in[i][31:0], 1'b0};
                    n_q[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[j][i] <= n_rem[i];
                    r_dv_q[j][i]   <= n_q[i];
                end
                r_dv_len[j]  <= len_in;
                r_dv_neg[j]  <= neg_in;
                r_dv_zero[j] <= zero_in;
            end
        end
    end

    // sign restore; a zero vector gives zero
    t_unit_vec n_o_unit;
    t_unit_vec r_o_unit;
    logic      r_o_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_zero[DIV_STG-1]) begin
                n_o_unit[i] = '0;
            end else if (r_dv_neg[DIV_STG-1][i]) begin
                n_o_unit[i] = -{1'b0, r_dv_q[DIV_STG-1][i]};
            end else begin
                n_o_unit[i] = {1'b0, r_dv_q[DIV_STG-1][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_o_vld <= r_dv_vld[DIV_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_o_unit <= n_o_unit;
        end
    end

    assign o_valid = r_o_vld;
    assign o_unit  = r_o_unit;

endmodule

// File: rtl/pfs_shade.sv
// pipelined lighting math: dot products, diffuse, reflection, specular power, output
module pfs_shade (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfs_pkg::t_pipe_ctl i_ctl,
    input  pfs_pkg::t_unit_vec i_n,
    input  pfs_pkg::t_unit_vec i_l,
    input  pfs_pkg::t_unit_vec i_v,
    output logic               o_valid,
    output logic [15:0]        o_red,
    output logic [15:0]        o_green,
    output logic [15:0]        o_blue
);
    import pfs_pkg::*;

    localparam int unsigned NSTG = 13;
    localparam t_unit ONE_Q30 = 32'sh4000_0000;
    localparam logic [15:0] OUT_MAX = 16'h8000;

    function automatic t_unit clamp_unit(input logic signed [63:0] x);
        t_unit y;
        if (x > 64'sd1073741824) begin
            y = ONE_Q30;
        end else if (x < -64'sd1073741824) begin
            y = -ONE_Q30;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = a * b;
        return p[60:30];
    endfunction

    function automatic logic [15:0] sat_chan(input logic [30:0] d, input logic [30:0] s);
        logic [31:0] sum;
        sum = {1'b0, d} + {1'b0, s};
        return (sum[31:16] > OUT_MAX) ? OUT_MAX : sum[31:16];
    endfunction

    logic [NSTG:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[NSTG-1:1], i_ctl.valid};
        end
    end

    // s1: n.l products and ny squared
    logic signed [63:0] n1_nl [3];
    logic signed [63:0] n1_nn;
    logic signed [63:0] r1_nl [3];
    logic signed [63:0] r1_nn;
    logic               r1_ny_pos;
    t_unit_vec          r1_n, r1_l, r1_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_nl[i] = $signed(i_n[i]) * $signed(i_l[i]);
        end
        n1_nn = $signed(i_n[1]) * $signed(i_n[1]);
    end

    // s2: n.l and diffuse tint
    logic signed [63:0] n2_raw;
    t_unit              r2_dnl;
    logic               r2_nonneg;
    logic [30:0]        r2_t;
    t_unit_vec          r2_n, r2_l, r2_v;

    assign n2_raw = r1_nl[0] + r1_nl[1] + r1_nl[2];

    // s3: tint times n.l, 2(n.l)n products
    logic [30:0]        n3_d;
    logic signed [63:0] n3_pr [3];
    logic [61:0]        r3_td;
    logic [30:0]        r3_d;
    logic signed [63:0] r3_pr [3];
    t_unit_vec          r3_l, r3_v;

    always_comb begin
        n3_d = r2_nonneg ? r2_dnl[30:0] : '0;
        for (int i = 0; i < 3; i++) begin
            n3_pr[i] = $signed(r2_dnl) * $signed(r2_n[i]);
        end
    end

    // s4: reflection vector
    logic signed [63:0] n4_tmp [3];
    t_unit_vec          n4_r;
    t_unit_vec          r4_r, r4_v;
    logic [30:0]        r4_rb, r4_g;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_tmp[i] = (r3_pr[i] >>> 29) - $signed(r3_l[i]);
            n4_r[i]   = clamp_unit(n4_tmp[i]);
        end
    end

    // s5: v.r products, s6: v.r
    logic signed [63:0] n5_vr [3];
    logic signed [63:0] r5_vr [3];
    logic signed [63:0] n6_raw;
    t_unit              n6_cl;
    logic [30:0]        r6_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_vr[i] = $signed(r4_v[i]) * $signed(r4_r[i]);
        end
        n6_raw = r5_vr[0] + r5_vr[1] + r5_vr[2];
        n6_cl  = clamp_unit(n6_raw >>> 30);
    end

    // s7..s12: power 40 by squarings
    logic [30:0] r7_p2, r8_p4, r9_p8, r10_p16, r10_p8, r11_p32, r11_p8, r12_spec;

    // diffuse rides along from s5 to s12
    logic [30:0] r_drb [5:12];
    logic [30:0] r_dg  [5:12];

    logic [15:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_nl     <= n1_nl;
            r1_nn     <= n1_nn;
            r1_ny_pos <= ($signed(i_n[1]) > 0);
            r1_n      <= i_n;
            r1_l      <= i_l;
            r1_v      <= i_v;

            r2_dnl    <= clamp_unit(n2_raw >>> 30);
            r2_nonneg <= !n2_raw[63];
            r2_t      <= r1_ny_pos ? r1_nn[60:30] : '0;
            r2_n      <= r1_n;
            r2_l      <= r1_l;
            r2_v      <= r1_v;

            r3_td     <= r2_t * n3_d;
            r3_d      <= n3_d;
            r3_pr     <= n3_pr;
            r3_l      <= r2_l;
            r3_v      <= r2_v;

            r4_r      <= n4_r;
            r4_rb     <= r3_td[60:30];
            r4_g      <= r3_d;
            r4_v      <= r3_v;

            r5_vr     <= n5_vr;
            r_drb[5]  <= r4_rb;
            r_dg[5]   <= r4_g;
            for (int k = 6; k <= 12; k++) begin
                r_drb[k] <= r_drb[k-1];
                r_dg[k]  <= r_dg[k-1];
            end

            r6_s      <= (n6_raw > 0) ? n6_cl[30:0] : '0;
            r7_p2     <= mulq(r6_s, r6_s);
            r8_p4     <= mulq(r7_p2, r7_p2);
            r9_p8     <= mulq(r8_p4, r8_p4);
            r10_p16   <= mulq(r9_p8, r9_p8);
            r10_p8    <= r9_p8;
            r11_p32   <= mulq(r10_p16, r10_p16);
            r11_p8    <= r10_p8;
            r12_spec  <= mulq(r11_p32, r11_p8);

            r_red     <= sat_chan(r_drb[12], r12_spec);
            r_green   <= sat_chan(r_dg[12], r12_spec);
            r_blue    <= sat_chan(r_drb[12], r12_spec);
        end
    end

    assign o_valid = r_vld[NSTG];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// File: rtl/phong_fragment_shade.sv
// top level of the per-pixel phong fragment shader
//
// usage:
//   config port: i_cfg_we with i_cfg_idx / i_cfg_data writes one of six
//   registers (light x/y/z, camera x/y/z, signed q16.16);
//   indexes six and seven are ignored. write only while the pipe is empty.
//   input channel: i_in_valid / o_in_ready carries one fragment request
//   (world position and raw normal, signed q16.16).
//   output channel: o_out_valid / i_out_ready carries one rgb request,
//   unsigned q2.14 per channel, saturated at 2.0.
// pipeline: 1 difference stage, 69 in the normalizers, 13 in the shading
//   math; the normalizers dominate: 32 square root stages and 31 divide stages.
// throughput: one fragment per clock while the receiver takes results.
// stall: when a result waits and i_out_ready is low the whole pipe holds;
//   o_in_ready drops in the same cycle, nothing is dropped or repeated.
// reset: synchronous, active low; clears all valid bits and the config
//   registers to zero; no clearing pass is needed.
module phong_fragment_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_frag_pos_x,
    input  logic signed [31:0]            i_frag_pos_y,
    input  logic signed [31:0]            i_frag_pos_z,
    input  logic signed [31:0]            i_surf_norm_x,
    input  logic signed [31:0]            i_surf_norm_y,
    input  logic signed [31:0]            i_surf_norm_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [15:0]                   o_red,
    output logic [15:0]                   o_green,
    output logic [15:0]                   o_blue
);
    import pfs_pkg::*;

    // configuration registers
    logic signed [31:0] r_light  [3];
    logic signed [31:0] r_camera [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_light[i]  <= '0;
                r_camera[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIGHT_X:  r_light[0]  <= i_cfg_data;
                CFG_LIGHT_Y:  r_light[1]  <= i_cfg_data;
                CFG_LIGHT_Z:  r_light[2]  <= i_cfg_data;
                CFG_CAMERA_X: r_camera[0] <= i_cfg_data;
                CFG_CAMERA_Y: r_camera[1] <= i_cfg_data;
                CFG_CAMERA_Z: r_camera[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipe moves together unless the output register is blocked
    logic      w_en;
    t_pipe_ctl w_in_ctl;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_in_ctl   = '{en: w_en, valid: i_in_valid};

    // difference stage: exact 33-bit light and view directions
    logic signed [31:0] w_pos [3];
    t_raw_vec           n_p_lv, n_p_vv, n_p_nrm;
    t_raw_vec           r_p_lv, r_p_vv, r_p_nrm;
    logic               r_p_vld;

    assign w_pos[0] = i_frag_pos_x;
    assign w_pos[1] = i_frag_pos_y;
    assign w_pos[2] = i_frag_pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p_lv[i] = 33'(r_light[i]) - 33'(w_pos[i]);
            n_p_vv[i] = 33'(r_camera[i]) - 33'(w_pos[i]);
        end
        n_p_nrm[0] = 33'(i_surf_norm_x);
        n_p_nrm[1] = 33'(i_surf_norm_y);
        n_p_nrm[2] = 33'(i_surf_norm_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= w_in_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_lv  <= n_p_lv;
            r_p_vv  <= n_p_vv;
            r_p_nrm <= n_p_nrm;
        end
    end

    // three normalizers in lockstep
    t_pipe_ctl w_u_ctl;
    t_unit_vec w_n, w_l, w_v;
    logic      w_n_vld, w_l_vld, w_v_vld;

    assign w_u_ctl = '{en: w_en, valid: r_p_vld};

    pfs_unitize u_unit_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_u_ctl),
        .i_vec   (r_p_nrm),
        .o_valid (w_n_vld),
        .o_unit  (w_n)
    );

    pfs_unitize u_unit_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_u_ctl),
        .i_vec   (r_p_lv),
        .o_valid (w_l_vld),
        .o_unit  (w_l)
    );

    pfs_unitize u_unit_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_u_ctl),
        .i_vec   (r_p_vv),
        .o_valid (w_v_vld),
        .o_unit  (w_v)
    );

    // lighting math, ends in the output register
    t_pipe_ctl w_s_ctl;

    assign w_s_ctl = '{en: w_en, valid: w_n_vld && w_l_vld && w_v_vld};

    pfs_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_s_ctl),
        .i_n     (w_n),
        .i_l     (w_l),
        .i_v     (w_v),
        .o_valid (o_out_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

// File: rtl/pfs_checker.sv
// port-level checks of the phong fragment shader and their bind
`include "assert_macros.svh"

module pfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_red,
    input logic [15:0] o_green,
    input logic [15:0] o_blue
);

    // a blocked result holds
    `PFS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue), "result changed while stalled")

    // reset empties the pipe
    `PFS_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // an empty output register never blocks new requests
    `PFS_ASSERT(a_ready_free, i_clk, i_rst_n, !o_out_valid |-> o_in_ready, "input stalled while output empty")

    // channels saturate at 2.0
    `PFS_ASSERT(a_sat, i_clk, i_rst_n, o_out_valid |-> (o_red <= 16'h8000) && (o_green <= 16'h8000) && (o_blue <= 16'h8000), "channel above saturation")

    // diffuse tint is (t,1,t), so red and blue always match
    `PFS_ASSERT(a_rb_equal, i_clk, i_rst_n, o_out_valid |-> o_red == o_blue, "red and blue differ")

endmodule

bind phong_fragment_shade pfs_checker u_pfs_checker (.*);
